// File: rtl/spq_pkg.sv
`timescale 1ns / 1ps

package spq_pkg;

    // Default depth of the cell chain
    localparam int unsigned CapacityDef = 16;

    // Field widths
    localparam int unsigned PrioW  = 32;
    localparam int unsigned ValueW = 32;
    localparam int unsigned CountW = 5;

    // Request codes
    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_REMOVE = 1'b1;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    // Per-beat command broadcast to every cell
    typedef struct packed {
        logic ins;   // insert that will be stored
        logic rem;   // remove that will pop the head
    } t_cell_op;

endpackage

// File: rtl/spq_cell.sv
`timescale 1ns / 1ps

module spq_cell
    import spq_pkg::*;
(
    input  logic                     i_clk,
    input  t_cell_op                 i_op,
    input  logic                     i_occupied,
    input  logic signed [PrioW-1:0]  i_new_prio,
    input  logic signed [ValueW-1:0] i_new_value,
    input  logic                     i_prev_keep,
    input  logic signed [PrioW-1:0]  i_prev_prio,
    input  logic signed [ValueW-1:0] i_prev_value,
    input  logic signed [PrioW-1:0]  i_next_prio,
    input  logic signed [ValueW-1:0] i_next_value,
    output logic                     o_keep,
    output logic signed [PrioW-1:0]  o_prio,
    output logic signed [ValueW-1:0] o_value
);

    logic signed [PrioW-1:0]  r_prio;
    logic signed [ValueW-1:0] r_value;
    logic signed [PrioW-1:0]  n_prio;
    logic signed [ValueW-1:0] n_value;

    // Entry stays put on insert when it is held and not above the new priority
    assign o_keep = i_occupied && (r_prio <= i_new_prio);

    // Hold, take the new entry, shift down from the left, or shift up from the right
    always_comb begin
        n_prio  = r_prio;
        n_value = r_value;
        if (i_op.ins) begin
            if (!o_keep) begin
                if (i_prev_keep) begin
                    n_prio  = i_new_prio;
                    n_value = i_new_value;
                end else begin
                    n_prio  = i_prev_prio;
                    n_value = i_prev_value;
                end
            end
        end else if (i_op.rem) begin
            n_prio  = i_next_prio;
            n_value = i_next_value;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prio  <= n_prio;
        r_value <= n_value;
    end

    assign o_prio  = r_prio;
    assign o_value = r_value;

endmodule

// File: rtl/sorted_priority_queue.sv
`timescale 1ns / 1ps
// Latency: a result is presented on the outputs the cycle after its request beat is accepted.
// Throughput: one insert or remove per cycle while o_ready is high; each cell compares and shifts.
// The output register holds a result while the next request is taken when it drains.
// Reset (synchronous, active low) empties the queue and the output register.
// Entry storage is not cleared; only cells below the fill count are ever read.
module sorted_priority_queue
    import spq_pkg::*;
#(
    parameter int unsigned CAPACITY = CapacityDef
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  logic                     i_req_type,
    input  logic signed [PrioW-1:0]  i_priority_req,
    input  logic signed [ValueW-1:0] i_value,
    output logic                     o_valid,
    input  logic                     i_ready,
    output logic signed [ValueW-1:0] o_removed_value,
    output logic [1:0]               o_status,
    output logic [CountW-1:0]        o_count,
    output logic                     o_is_empty
);

    localparam int unsigned CW = $clog2(CAPACITY + 1);

    logic [CW-1:0]            r_count;
    logic [CW-1:0]            n_count;
    logic                     r_out_valid;
    logic signed [ValueW-1:0] r_removed_value;
    t_status                  r_status;
    logic [CountW-1:0]        r_out_count;
    logic                     r_is_empty;

    logic                     w_accept;
    logic                     w_full;
    logic                     w_empty;
    t_cell_op                 w_op;
    t_status                  w_status;
    logic [CW+CountW-1:0]     w_count_ext;

    logic                     w_keep  [CAPACITY];
    logic signed [PrioW-1:0]  w_prio  [CAPACITY];
    logic signed [ValueW-1:0] w_val   [CAPACITY];

    // Handshake: take a beat whenever the result register is free or draining
    assign o_ready  = !r_out_valid || i_ready;
    assign w_accept = i_valid && o_ready;

    assign w_full  = (r_count == CW'(CAPACITY));
    assign w_empty = (r_count == '0);

    // Command and count update
    always_comb begin
        w_op.ins = 1'b0;
        w_op.rem = 1'b0;
        w_status = ST_OK;
        n_count  = r_count;
        if (w_accept) begin
            if (i_req_type == REQ_INSERT) begin
                if (w_full) begin
                    w_status = ST_FULL;
                end else begin
                    w_op.ins = 1'b1;
                    n_count  = r_count + CW'(1);
                end
            end else begin
                if (w_empty) begin
                    w_status = ST_EMPTY;
                end else begin
                    w_op.rem = 1'b1;
                    n_count  = r_count - CW'(1);
                end
            end
        end
    end

    assign w_count_ext = {{CountW{1'b0}}, n_count};

    // Cell chain, head at index 0
    for (genvar gi = 0; gi < CAPACITY; gi++) begin : g_cell
        localparam int unsigned Prev = (gi == 0) ? 0 : gi - 1;
        localparam int unsigned Next = (gi == CAPACITY - 1) ? gi : gi + 1;

        spq_cell u_cell (
            .i_clk        (i_clk),
            .i_op         (w_op),
            .i_occupied   (CW'(gi) < r_count),
            .i_new_prio   (i_priority_req),
            .i_new_value  (i_value),
            .i_prev_keep  ((gi == 0) ? 1'b1 : w_keep[Prev]),
            .i_prev_prio  (w_prio[Prev]),
            .i_prev_value (w_val[Prev]),
            .i_next_prio  (w_prio[Next]),
            .i_next_value (w_val[Next]),
            .o_keep       (w_keep[gi]),
            .o_prio       (w_prio[gi]),
            .o_value      (w_val[gi])
        );
    end

    // Fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_accept) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_removed_value <= w_op.rem ? w_val[0] : '0;
            r_status        <= w_status;
            r_out_count     <= w_count_ext[CountW-1:0];
            r_is_empty      <= (n_count == '0);
        end
    end

    assign o_valid         = r_out_valid;
    assign o_removed_value = r_removed_value;
    assign o_status        = r_status;
    assign o_count         = r_out_count;
    assign o_is_empty      = r_is_empty;

    // Checks
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("fill count above capacity");

    a_insert_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_op.ins |=> r_count == $past(r_count) + CW'(1))
        else $error("insert did not grow the queue");

    a_pop_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_op.rem |=> r_removed_value == $past(w_val[0]) && r_status == ST_OK)
        else $error("remove did not return the head entry");

    a_empty_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && i_req_type == REQ_REMOVE && w_empty
        |=> r_status == ST_EMPTY && r_is_empty && r_removed_value == '0)
        else $error("remove on empty queue reported wrongly");

    a_full_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && i_req_type == REQ_INSERT && w_full |=> $stable(r_count))
        else $error("dropped insert changed the count");

endmodule

// File: bench/tb_sorted_priority_queue.sv
`timescale 1ns / 1ps

module tb_sorted_priority_queue;
    import spq_pkg::*;

    localparam int unsigned QDEPTH     = CapacityDef;
    localparam int          NUM_RANDOM = 1300;
    localparam int          QUIET_TAIL = 150;
    localparam int          WD_LIMIT   = 2000;
    localparam int          LONG_HOLD  = 80;

    // One request beat plus the pacing hints attached to it
    typedef struct packed {
        logic              req_type;
        logic [PrioW-1:0]  prio;
        logic [ValueW-1:0] value;
        logic              drain_first;
        logic              may_gap;
        logic              tail;
    } pq_req_t;

    typedef struct packed {
        logic [ValueW-1:0] removed_value;
        t_status           status;
        logic [CountW-1:0] count;
        logic              is_empty;
    } pq_result_t;

    logic                     i_clk           = 1'b0;
    logic                     i_rst_n         = 1'b0;
    logic                     i_valid         = 1'b0;
    logic                     i_req_type      = REQ_INSERT;
    logic signed [PrioW-1:0]  i_priority_req  = '0;
    logic signed [ValueW-1:0] i_value         = '0;
    logic                     i_ready         = 1'b0;
    logic                     o_ready;
    logic                     o_valid;
    logic signed [ValueW-1:0] o_removed_value;
    logic [1:0]               o_status;
    logic [CountW-1:0]        o_count;
    logic                     o_is_empty;

    sorted_priority_queue #(
        .CAPACITY(QDEPTH)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_req_type     (i_req_type),
        .i_priority_req (i_priority_req),
        .i_value        (i_value),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_removed_value(o_removed_value),
        .o_status       (o_status),
        .o_count        (o_count),
        .o_is_empty     (o_is_empty)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    pq_req_t    stim_queue[$];
    pq_result_t pending_results[$];
    pq_result_t want;

    int beats_in   = 0;
    int beats_out  = 0;
    int n_err      = 0;
    int gap_left   = 0;
    int hold_left  = 0;
    int long_holds = 0;
    int wd_count   = 0;
    logic rx_quiet = 1'b0;
    logic rx_calm  = 1'b0;
    pq_req_t cur;

    // Generator state: fill estimate and flags for the next queued beat
    int unsigned gen_fill  = 0;
    int          gen_count = 0;
    logic        gen_gap   = 1'b1;
    logic        gen_drain = 1'b0;

    // Sorted-list shadow of the queue contents
    logic signed [PrioW-1:0] sorted_prio  [QDEPTH];
    logic [ValueW-1:0]       sorted_value [QDEPTH];
    int unsigned             sorted_count = 0;

    // Apply one request to the shadow list and return the result it yields
    function automatic pq_result_t model_request(input logic kind,
                                                 input logic signed [PrioW-1:0] prio,
                                                 input logic [ValueW-1:0] value);
        pq_result_t  res;
        int unsigned pos;
        int unsigned i;
        res.removed_value = '0;
        res.status        = ST_OK;
        if (kind == REQ_INSERT) begin
            if (sorted_count >= QDEPTH) begin
                res.status = ST_FULL;
            end else begin
                // new entry goes behind all equal or lower priorities
                pos = 0;
                while (pos < sorted_count && sorted_prio[pos] <= prio)
                    pos++;
                for (i = sorted_count; i > pos; i--) begin
                    sorted_prio[i]  = sorted_prio[i-1];
                    sorted_value[i] = sorted_value[i-1];
                end
                sorted_prio[pos]  = prio;
                sorted_value[pos] = value;
                sorted_count++;
            end
        end else begin
            if (sorted_count == 0) begin
                res.status = ST_EMPTY;
            end else begin
                res.removed_value = sorted_value[0];
                for (i = 0; i + 1 < sorted_count; i++) begin
                    sorted_prio[i]  = sorted_prio[i+1];
                    sorted_value[i] = sorted_value[i+1];
                end
                sorted_count--;
            end
        end
        res.count    = CountW'(sorted_count);
        res.is_empty = (sorted_count == 0);
        return res;
    endfunction

    // Priority mix: heavy on near ties, some extremes, some whole Q16.16 values
    function automatic logic [PrioW-1:0] pick_prio();
        logic [PrioW-1:0] p;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: p = PrioW'(int'($urandom_range(0, 6)) - 3);
            4: begin
                case ($urandom_range(0, 3))
                    0:       p = 32'h8000_0000;
                    1:       p = 32'h7FFF_FFFF;
                    2:       p = '0;
                    default: p = '1;
                endcase
            end
            5:       p = {16'(int'($urandom_range(0, 63)) - 32), 16'h0000};
            default: p = $urandom();
        endcase
        return p;
    endfunction

    task automatic queue_req(input logic kind, input logic [PrioW-1:0] prio,
                             input logic [ValueW-1:0] value);
        pq_req_t item;
        item.req_type    = kind;
        item.prio        = prio;
        item.value       = value;
        item.drain_first = gen_drain;
        item.may_gap     = gen_gap;
        item.tail        = 1'b0;
        stim_queue.push_back(item);
        gen_drain = 1'b0;
        gen_count++;
        if (kind == REQ_INSERT) begin
            if (gen_fill < QDEPTH) gen_fill++;
        end else if (gen_fill > 0) begin
            gen_fill--;
        end
    endtask

    // Sender: presents queued beats, random gaps, optional drain before a beat
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && o_ready) beats_in <= beats_in + 1;
            if (!i_valid || o_ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    i_valid <= 1'b0;
                end else if (stim_queue.size() == 0) begin
                    i_valid <= 1'b0;
                end else if (stim_queue[0].drain_first && (i_valid || beats_in != beats_out)) begin
                    i_valid <= 1'b0;
                end else if (stim_queue[0].may_gap && $urandom_range(0, 7) == 0) begin
                    gap_left = $urandom_range(1, 12) - 1;
                    i_valid <= 1'b0;
                end else begin
                    cur = stim_queue.pop_front();
                    i_valid        <= 1'b1;
                    i_req_type     <= cur.req_type;
                    i_priority_req <= cur.prio;
                    i_value        <= cur.value;
                    rx_quiet       <= cur.tail;
                end
            end
        end
    end

    // Receiver: checks result beats, predicts on request beats, paces i_ready
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            // result first: a request taken this edge cannot answer yet
            if (o_valid && i_ready) begin
                beats_out <= beats_out + 1;
                if ($urandom_range(0, 49) == 0) rx_calm = !rx_calm;
                if (pending_results.size() == 0) begin
                    $error("result beat with no request outstanding");
                    n_err++;
                end else begin
                    want = pending_results.pop_front();
                    if (o_removed_value !== want.removed_value) begin
                        $error("removed_value: expected %h, got %h",
                               want.removed_value, o_removed_value);
                        n_err++;
                    end
                    if (o_status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, o_status);
                        n_err++;
                    end
                    if (o_count !== want.count) begin
                        $error("count: expected %0d, got %0d", want.count, o_count);
                        n_err++;
                    end
                    if (o_is_empty !== want.is_empty) begin
                        $error("is_empty: expected %0d, got %0d", want.is_empty, o_is_empty);
                        n_err++;
                    end
                end
            end
            if (i_valid && o_ready)
                pending_results.push_back(model_request(i_req_type, i_priority_req, i_value));

            // long hold-offs let the block back up and stall its input
            if (hold_left > 0) begin
                hold_left--;
                i_ready <= 1'b0;
            end else if ((long_holds == 0 && beats_out >= 40) ||
                         (long_holds == 1 && beats_out >= 600)) begin
                long_holds++;
                hold_left = LONG_HOLD - 1;
                i_ready <= 1'b0;
            end else if (!rx_quiet && !rx_calm && $urandom_range(0, 5) == 0) begin
                hold_left = $urandom_range(1, 12) - 1;
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    // Watchdog on cycles with no beat on either side
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) begin
            wd_count <= 0;
        end else if (wd_count >= WD_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end else begin
            wd_count <= wd_count + 1;
        end
    end

    initial begin
        int          k;
        int          mode;
        int          len;
        int          ins_pct;
        int          extra;
        pq_req_t     item;

        // directed: empty pop, extremes, ties, fill to full, overflow, pops
        queue_req(REQ_REMOVE, 32'h0, 32'h0);
        queue_req(REQ_INSERT, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
        queue_req(REQ_INSERT, 32'h8000_0000, 32'h8000_0000);
        queue_req(REQ_INSERT, 32'h0000_0000, 32'h0000_0000);
        queue_req(REQ_INSERT, 32'h0001_0000, 32'h0000_0001);
        queue_req(REQ_INSERT, 32'h0001_0000, 32'h0000_0002);
        queue_req(REQ_INSERT, 32'h0001_0000, 32'h0000_0003);
        queue_req(REQ_INSERT, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
        queue_req(REQ_INSERT, 32'h7FFF_FFFF, 32'h1234_5678);
        queue_req(REQ_INSERT, 32'h8000_0000, 32'h5555_AAAA);
        queue_req(REQ_INSERT, 32'h0000_FFFF, 32'hAAAA_5555);
        queue_req(REQ_INSERT, 32'h0001_0001, 32'h0F0F_0F0F);
        queue_req(REQ_INSERT, 32'hFFFF_0000, 32'hF0F0_F0F0);
        queue_req(REQ_INSERT, 32'h7FFF_FFFE, 32'h0000_0004);
        queue_req(REQ_INSERT, 32'h8000_0001, 32'h0000_0005);
        queue_req(REQ_INSERT, 32'h0001_0000, 32'h0000_0006);
        queue_req(REQ_INSERT, 32'h0000_0001, 32'h0000_0007);
        queue_req(REQ_INSERT, 32'h0000_0000, 32'hDEAD_BEEF);
        queue_req(REQ_INSERT, 32'h8000_0000, 32'hCAFE_F00D);
        repeat (5) queue_req(REQ_REMOVE, $urandom(), $urandom());

        // random: fill/drain runs plus mixed runs of varying insert bias
        gen_drain = 1'b1;
        while (gen_count < NUM_RANDOM + 24) begin
            mode    = $urandom_range(0, 4);
            gen_gap = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 5) == 0) gen_drain = 1'b1;
            case (mode)
                0: begin
                    extra = $urandom_range(1, 3);
                    while (gen_fill < QDEPTH) queue_req(REQ_INSERT, pick_prio(), $urandom());
                    repeat (extra) queue_req(REQ_INSERT, pick_prio(), $urandom());
                end
                1: begin
                    extra = $urandom_range(1, 2);
                    while (gen_fill > 0) queue_req(REQ_REMOVE, $urandom(), $urandom());
                    repeat (extra) queue_req(REQ_REMOVE, $urandom(), $urandom());
                end
                default: begin
                    len     = $urandom_range(10, 60);
                    ins_pct = (mode == 2) ? 50 : (mode == 3) ? 75 : 25;
                    repeat (len) begin
                        if ($urandom_range(0, 99) < ins_pct)
                            queue_req(REQ_INSERT, pick_prio(), $urandom());
                        else
                            queue_req(REQ_REMOVE, $urandom(), $urandom());
                    end
                end
            endcase
        end

        // closing stretch runs with no idling on either side
        for (k = stim_queue.size() - QUIET_TAIL; k < stim_queue.size(); k++) begin
            item             = stim_queue[k];
            item.tail        = 1'b1;
            item.may_gap     = 1'b0;
            item.drain_first = 1'b0;
            stim_queue[k]    = item;
        end

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        do @(negedge i_clk);
        while (stim_queue.size() != 0 || i_valid || beats_in != beats_out);
        repeat (8) @(negedge i_clk);

        if (pending_results.size() != 0) begin
            $error("%0d expected results never arrived", pending_results.size());
            n_err++;
        end
        if (n_err == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
